// File: rtl/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, types and codes of the sliding window sender.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SEQ_BITS    = 20;
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W       = SEQ_BITS + 1;
   localparam int WIN_W       = 6;
   localparam int TIMEOUT_W   = 16;
   localparam int TOTAL_W     = 20;
   localparam int TIME_W      = 32;
   localparam int RESEND_W    = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [WIN_W-1:0]     WINDOW_RESET  = WIN_W'(10);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1500);
   localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = TOTAL_W'(20000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE    = 2'd0,
      CSR_TIMEOUT_TICKS  = 2'd1,
      CSR_TOTAL_MESSAGES = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_TICK,
      EV_ACK,
      EV_NULL_ACK
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type         kind;
      logic [SEQ_BITS-1:0] ack;
   } event_type;

   typedef struct packed {
      logic [WIN_W-1:0]     window_size;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [TOTAL_W-1:0]   total_messages;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_SEND,
      ST_RESEND
   } state_type;

endpackage

// File: rtl/sws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_front
// Input stage: takes request transactions and tags them as tick, ACK or null ACK.
// ----------------------------------------------------------------------------
module sws_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [sws_pkg::SEQ_BITS-1:0]  req_ack_number,
   output logic                          ev_valid,
   input  logic                          ev_ready,
   output sws_pkg::event_type            ev_data
);

   logic               hold_valid_ff, hold_valid_in;
   sws_pkg::event_type hold_ev_ff, hold_ev_in;
   logic               accept;

   assign req_ready = !hold_valid_ff || ev_ready;
   assign accept    = req_valid && req_ready;
   assign ev_valid  = hold_valid_ff;
   assign ev_data   = hold_ev_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_ev_in    = hold_ev_ff;
      if (accept) begin
         hold_valid_in  = 1'b1;
         hold_ev_in.ack = req_ack_number;
         if (!req_action) begin
            hold_ev_in.kind = sws_pkg::EV_TICK;
         end else if (req_ack_number == '0) begin
            hold_ev_in.kind = sws_pkg::EV_NULL_ACK;
         end else begin
            hold_ev_in.kind = sws_pkg::EV_ACK;
         end
      end else if (ev_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ev_ff <= hold_ev_in;
   end

endmodule

// File: rtl/sws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_queue
// Short FIFO of classified events between the front and back ends.
// ----------------------------------------------------------------------------
module sws_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sws_pkg::event_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sws_pkg::event_type pop_data
);

   sws_pkg::event_type          slot_ff [sws_pkg::QUEUE_DEPTH];
   logic [sws_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sws_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sws_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = count_ff != (sws_pkg::QPTR_W + 1)'(sws_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_back
// Window engine: retires ACKed entries, issues new sends, resends on timeout.
// ----------------------------------------------------------------------------
module sws_back (
   input  logic                            clock,
   input  logic                            reset,
   input  sws_pkg::cfg_type                cfg,
   input  logic                            ev_valid,
   output logic                            ev_ready,
   input  sws_pkg::event_type              ev_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sws_pkg::SEQ_BITS-1:0]    rsp_send_sequence,
   output logic                            rsp_is_resend,
   output logic                            rsp_last_of_run,
   output logic                            rsp_all_acked,
   output logic [sws_pkg::RESEND_W-1:0]    rsp_resend_total
);

   localparam int SEQ_BITS = sws_pkg::SEQ_BITS;
   localparam int CNT_W    = sws_pkg::CNT_W;
   localparam int SLOT_W   = sws_pkg::SLOT_W;
   localparam int SUM_W    = sws_pkg::SUM_W;
   localparam int TIME_W   = sws_pkg::TIME_W;
   localparam int RESEND_W = sws_pkg::RESEND_W;

   sws_pkg::state_type   state_ff, state_in;
   logic [SEQ_BITS-1:0]  next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]     in_flight_ff, in_flight_in;
   logic [SEQ_BITS-1:0]  acked_ff, acked_in;
   logic [SLOT_W-1:0]    oldest_ff, oldest_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [RESEND_W-1:0]  resend_cnt_ff, resend_cnt_in;
   logic                 resend_pend_ff, resend_pend_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SEQ_BITS-1:0]  rsp_seq_ff, rsp_seq_in;
   logic                 rsp_resend_ff, rsp_resend_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_all_ff, rsp_all_in;
   logic [RESEND_W-1:0]  rsp_total_ff, rsp_total_in;

   // stamp ring
   logic [TIME_W-1:0]    ring [sws_pkg::MAX_WINDOW];
   logic [TIME_W-1:0]    stamp_rd_ff;
   logic                 ring_we;
   logic [SLOT_W-1:0]    ring_waddr;

   logic [CNT_W-1:0]     win;
   logic [SUM_W-1:0]     issued;
   logic [SUM_W-1:0]     total_ext;
   logic [CNT_W-1:0]     in_flight_inc;
   logic                 can_send, can_send_more, all_acked, out_free;
   logic [SEQ_BITS-1:0]  ack_diff;
   logic [CNT_W-1:0]     drop;
   logic [TIME_W-1:0]    waited;
   logic [RESEND_W-1:0]  resend_sat;

   always_comb begin
      win = (cfg.window_size > sws_pkg::WIN_W'(sws_pkg::MAX_WINDOW))
          ? CNT_W'(sws_pkg::MAX_WINDOW) : CNT_W'(cfg.window_size);
      issued        = SUM_W'(acked_ff) + SUM_W'(in_flight_ff);
      total_ext     = SUM_W'(cfg.total_messages);
      in_flight_inc = in_flight_ff + CNT_W'(1);
      can_send      = (in_flight_ff < win) && (issued < total_ext);
      can_send_more = (in_flight_inc < win) && ((issued + SUM_W'(1)) < total_ext);
      all_acked     = SUM_W'(acked_ff) >= total_ext;
      out_free      = !rsp_valid_ff || rsp_ready;
      ack_diff      = ev_data.ack - acked_ff;
      drop = (ack_diff > SEQ_BITS'(in_flight_ff)) ? in_flight_ff : CNT_W'(ack_diff);
      waited        = time_ff - stamp_rd_ff;
      resend_sat    = (resend_cnt_ff == '1) ? resend_cnt_ff : resend_cnt_ff + 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      next_seq_in    = next_seq_ff;
      in_flight_in   = in_flight_ff;
      acked_in       = acked_ff;
      oldest_in      = oldest_ff;
      time_in        = time_ff;
      resend_cnt_in  = resend_cnt_ff;
      resend_pend_in = resend_pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_seq_in     = rsp_seq_ff;
      rsp_resend_in  = rsp_resend_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_all_in     = rsp_all_ff;
      rsp_total_in   = rsp_total_ff;
      ev_ready       = 1'b0;
      ring_we        = 1'b0;
      ring_waddr     = oldest_ff + SLOT_W'(in_flight_ff);

      case (state_ff)
         sws_pkg::ST_IDLE: begin
            ev_ready = 1'b1;
            if (ev_valid) begin
               state_in = sws_pkg::ST_READ;
               case (ev_data.kind)
                  sws_pkg::EV_TICK: begin
                     time_in = time_ff + 1'b1;
                  end
                  sws_pkg::EV_ACK: begin
                     if (ev_data.ack > acked_ff) begin
                        acked_in     = acked_ff + SEQ_BITS'(drop);
                        in_flight_in = in_flight_ff - drop;
                        oldest_in    = oldest_ff + SLOT_W'(drop);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sws_pkg::ST_READ: begin
            // stamp of the oldest entry lands in stamp_rd_ff this cycle
            state_in = sws_pkg::ST_CHECK;
         end
         sws_pkg::ST_CHECK: begin
            // a window that is empty now only gets fresh stamps (zero wait)
            if (in_flight_ff != '0) begin
               resend_pend_in = waited >= TIME_W'(cfg.timeout_ticks);
            end else begin
               resend_pend_in = can_send && (cfg.timeout_ticks == '0);
            end
            state_in = sws_pkg::ST_SEND;
         end
         sws_pkg::ST_SEND: begin
            if (!can_send) begin
               state_in = resend_pend_ff ? sws_pkg::ST_RESEND : sws_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_seq_in    = next_seq_ff;
               rsp_resend_in = 1'b0;
               rsp_last_in   = !can_send_more && !resend_pend_ff;
               rsp_all_in    = all_acked;
               rsp_total_in  = resend_cnt_ff;
               ring_we       = 1'b1;
               in_flight_in  = in_flight_inc;
               next_seq_in   = next_seq_ff + 1'b1;
            end
         end
         sws_pkg::ST_RESEND: begin
            ring_waddr = oldest_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_seq_in    = acked_ff + 1'b1;
               rsp_resend_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_all_in    = all_acked;
               rsp_total_in  = resend_sat;
               resend_cnt_in = resend_sat;
               ring_we       = 1'b1;
               state_in      = sws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sws_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sws_pkg::ST_IDLE;
         next_seq_ff    <= SEQ_BITS'(1);
         in_flight_ff   <= '0;
         acked_ff       <= '0;
         oldest_ff      <= '0;
         time_ff        <= '0;
         resend_cnt_ff  <= '0;
         resend_pend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_seq_ff    <= next_seq_in;
         in_flight_ff   <= in_flight_in;
         acked_ff       <= acked_in;
         oldest_ff      <= oldest_in;
         time_ff        <= time_in;
         resend_cnt_ff  <= resend_cnt_in;
         resend_pend_ff <= resend_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_seq_ff    <= rsp_seq_in;
      rsp_resend_ff <= rsp_resend_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_all_ff    <= rsp_all_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[ring_waddr] <= time_ff;
      end
      stamp_rd_ff <= ring[oldest_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_sequence = rsp_seq_ff;
   assign rsp_is_resend     = rsp_resend_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_all_acked     = rsp_all_ff;
   assign rsp_resend_total  = rsp_total_ff;

   // window never holds more than the ring depth
   assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= CNT_W'(sws_pkg::MAX_WINDOW))
      else $error("in_flight exceeds ring depth");

   // next sequence number always sits just past the ACKed plus in-flight span
   assert property (@(posedge clock) disable iff (reset)
      next_seq_ff == SEQ_BITS'(acked_ff + SEQ_BITS'(in_flight_ff) + SEQ_BITS'(1)))
      else $error("sequence bookkeeping out of step");

   // a resend always closes the run of its event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_resend_ff) |-> rsp_last_ff)
      else $error("resend not marked last of run");

   // the resend count only moves upward
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (resend_cnt_ff >= $past(resend_cnt_ff)))
      else $error("resend count decreased");

endmodule

// File: rtl/sliding_window_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender
// Sender side of a sliding-window transfer with cumulative ACKs.
// ----------------------------------------------------------------------------
// Each request transaction is a clock tick (action 0) or a cumulative ACK
// (action 1). The front end registers and tags it and drops it into a
// two-entry queue; the back end engine then retires ACKed entries, issues
// every new sequence number the window and message total allow (one response
// per cycle while the response channel is not stalled), and finally resends
// the oldest entry alone if it has waited at least timeout_ticks. The engine
// steps through its states in order: apply the event, read the stamp ring,
// check the timeout, then send responses until the run ends. Response
// backpressure stalls only the engine; the queue keeps taking requests until
// it fills. The stamp ring needs no clearing pass after reset. CSR writes
// are registered and are meant for quiet periods only.
// ----------------------------------------------------------------------------
module sliding_window_sender (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [sws_pkg::SEQ_BITS-1:0]     req_ack_number,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sws_pkg::SEQ_BITS-1:0]     rsp_send_sequence,
   output logic                             rsp_is_resend,
   output logic                             rsp_last_of_run,
   output logic                             rsp_all_acked,
   output logic [sws_pkg::RESEND_W-1:0]     rsp_resend_total,
   // CSR write port
   input  logic                             csr_wr_en,
   input  logic [sws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sws_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   sws_pkg::cfg_type   cfg_ff, cfg_in;

   logic               fe_valid, fe_ready;
   sws_pkg::event_type fe_data;
   logic               q_valid, q_ready;
   sws_pkg::event_type q_data;

   // CSR bank: a write to an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sws_pkg::CSR_WINDOW_SIZE: begin
               cfg_in.window_size = csr_wr_data[sws_pkg::WIN_W-1:0];
            end
            sws_pkg::CSR_TIMEOUT_TICKS: begin
               cfg_in.timeout_ticks = csr_wr_data[sws_pkg::TIMEOUT_W-1:0];
            end
            sws_pkg::CSR_TOTAL_MESSAGES: begin
               cfg_in.total_messages = csr_wr_data[sws_pkg::TOTAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size    <= sws_pkg::WINDOW_RESET;
         cfg_ff.timeout_ticks  <= sws_pkg::TIMEOUT_RESET;
         cfg_ff.total_messages <= sws_pkg::TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: take and tag the transaction
   sws_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_ack_number (req_ack_number),
      .ev_valid       (fe_valid),
      .ev_ready       (fe_ready),
      .ev_data        (fe_data)
   );

   // decoupling queue
   sws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  (fe_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // back end: window bookkeeping and response generation
   sws_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .ev_valid          (q_valid),
      .ev_ready          (q_ready),
      .ev_data           (q_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_sequence (rsp_send_sequence),
      .rsp_is_resend     (rsp_is_resend),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_all_acked     (rsp_all_acked),
      .rsp_resend_total  (rsp_resend_total)
   );

endmodule
